### design/sbmd_pkg.sv
// Shared types, constants and codes of the striped bounded message deque.
package sbmd_pkg;

  // Geometry
  localparam int SUBQUEUES  = 4;
  localparam int SUB_W      = $clog2(SUBQUEUES);
  localparam int SUB_DEPTH  = 256;
  localparam int PTR_W      = $clog2(SUB_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int MEM_DEPTH  = SUBQUEUES * SUB_DEPTH;
  localparam int MEM_AW     = SUB_W + PTR_W;
  localparam int MSG_BITS   = 32;

  // Configuration
  localparam int LIMIT_W    = 11;
  localparam int CAP_W      = LIMIT_W + 1 - SUB_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NONBLOCKING = 1'd1;

  // Request and response field widths
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OUT_USER_W = STATUS_W + SUB_W;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_PUT_BACK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUT_FRONT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET       = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd3;

  // Decoded request kind
  typedef enum logic [1:0] {
    OP_PUT_BACK  = 2'd0,
    OP_PUT_FRONT = 2'd1,
    OP_GET       = 2'd2,
    OP_NONE      = 2'd3
  } op_kind_t;

  // Request as it travels from decode to execution
  typedef struct packed {
    op_kind_t              kind;
    logic [MSG_BITS-1:0]   msg;
  } op_t;

  // Depth of the queue between front and back
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

endpackage

### design/striped_bounded_message_deque.sv
// Top level of the striped bounded message deque.
// Four sub-deques of 32-bit message handles share one 1024-slot memory.
// Puts and push-fronts go round-robin over the sub-deques, gets on a
// separate round-robin; every request gives exactly one response. A
// two-entry request queue sits between the decode front end and the
// execution back end; the back end takes the next request only when the
// response register is empty or being taken. A put, push-front,
// refusal, drop or empty answer loads the response register directly; a
// successful get first passes S_FETCH for the registered read of the slot
// memory. No clearing pass is needed after reset. Write queue_limit
// (index 0) and nonblocking (index 1) only while the block is idle.
module striped_bounded_message_deque (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [sbmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbmd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbmd_pkg::MSG_BITS-1:0]     in_tdata,   // [31:0] msg_in
  input  logic [sbmd_pkg::FUNC_W-1:0]       in_tuser,   // [1:0] func
  // Response channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbmd_pkg::MSG_BITS-1:0]     out_tdata,  // [31:0] msg_out
  output logic [sbmd_pkg::OUT_USER_W-1:0]   out_tuser   // [1:0] status, [3:2] sub_used
);

  logic           q_full, q_push, q_valid, q_pop;
  sbmd_pkg::op_t  push_op, head_op;

  // Decode requests
  sbmd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  // Buffer decoded requests
  sbmd_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  // Execute requests and hold responses
  sbmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_op       (head_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### design/sbmd_front.sv
// Front end: take requests from the input channel and classify them.
module sbmd_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sbmd_pkg::MSG_BITS-1:0]   in_tdata,
  input  logic [sbmd_pkg::FUNC_W-1:0]     in_tuser,
  input  logic                            q_full,
  output logic                            q_push,
  output sbmd_pkg::op_t                   q_op
);

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Decode the request code; unused codes change no state but still get a response
  always_comb begin
    q_op.msg = in_tdata;
    unique case (in_tuser)
      sbmd_pkg::FUNC_PUT_BACK:  q_op.kind = sbmd_pkg::OP_PUT_BACK;
      sbmd_pkg::FUNC_PUT_FRONT: q_op.kind = sbmd_pkg::OP_PUT_FRONT;
      sbmd_pkg::FUNC_GET:       q_op.kind = sbmd_pkg::OP_GET;
      default:                  q_op.kind = sbmd_pkg::OP_NONE;
    endcase
  end

endmodule

### design/sbmd_opq.sv
// Short request queue between the front end and the back end.
module sbmd_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbmd_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output sbmd_pkg::op_t head_op
);

  sbmd_pkg::op_t                   entry_r [sbmd_pkg::OPQ_DEPTH];
  logic [sbmd_pkg::OPQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sbmd_pkg::OPQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sbmd_pkg::OPQ_CW-1:0]     count_r, count_nxt;
  logic                            do_pop;

  assign full    = (count_r == sbmd_pkg::OPQ_CW'(sbmd_pkg::OPQ_DEPTH));
  assign valid   = (count_r != '0);
  assign head_op = entry_r[rd_ptr_r];
  assign do_pop  = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sbmd_pkg::OPQ_AW'(sbmd_pkg::OPQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbmd_pkg::OPQ_AW'(sbmd_pkg::OPQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### design/sbmd_back.sv
// Back end: sub-deque bookkeeping, slot memory and the response register.
module sbmd_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbmd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              q_valid,
  input  sbmd_pkg::op_t                     q_op,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbmd_pkg::MSG_BITS-1:0]     out_tdata,
  output logic [sbmd_pkg::OUT_USER_W-1:0]   out_tuser
);

  typedef enum logic [1:0] {
    S_RUN   = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  localparam int SW = sbmd_pkg::SUB_W;
  localparam int PW = sbmd_pkg::PTR_W;
  localparam int CW = sbmd_pkg::CNT_W;

  state_t                              state_r, state_nxt;
  logic [sbmd_pkg::LIMIT_W-1:0]        limit_r;
  logic                                nonblk_r;

  logic [PW-1:0]                       front_ptr_r [sbmd_pkg::SUBQUEUES];
  logic [CW-1:0]                       total_r     [sbmd_pkg::SUBQUEUES];
  logic [CW-1:0]                       put_cnt_r   [sbmd_pkg::SUBQUEUES];
  logic [SW-1:0]                       put_rr_r, put_rr_nxt;
  logic [SW-1:0]                       get_rr_r, get_rr_nxt;

  logic [sbmd_pkg::MSG_BITS-1:0]       mem [sbmd_pkg::MEM_DEPTH];
  logic [sbmd_pkg::MSG_BITS-1:0]       rd_data_r;

  logic                                out_valid_r;
  logic [sbmd_pkg::MSG_BITS-1:0]       out_msg_r;
  logic [sbmd_pkg::STATUS_W-1:0]       out_status_r;
  logic [SW-1:0]                       out_sub_r;
  logic [SW-1:0]                       pend_sub_r;

  logic                                out_free;
  logic [SW-1:0]                       sub_c;
  logic [PW-1:0]                       front_c;
  logic [CW-1:0]                       total_c, put_cnt_c;
  logic [sbmd_pkg::LIMIT_W:0]          cap_sum_c;
  logic [sbmd_pkg::CAP_W-1:0]          cap_c;
  logic                                part_full_c, into_get_c;
  logic                                upd_c, wr_en_c, load_c;
  logic [PW-1:0]                       front_nxt;
  logic [CW-1:0]                       total_nxt, put_cnt_nxt;
  logic [PW-1:0]                       wr_slot_c;
  logic [sbmd_pkg::STATUS_W-1:0]       res_status_c;
  logic [SW-1:0]                       res_sub_c;

  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = (state_r == S_RUN) && q_valid && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_msg_r;
  assign out_tuser  = {out_sub_r, out_status_r};

  // Look up the sub-deque that this request works on
  assign sub_c     = (q_op.kind == sbmd_pkg::OP_GET) ? get_rr_r : put_rr_r;
  assign front_c   = front_ptr_r[sub_c];
  assign total_c   = total_r[sub_c];
  assign put_cnt_c = put_cnt_r[sub_c];

  // Put-part capacity is the limit split across sub-deques, rounded up
  assign cap_sum_c   = {1'b0, limit_r} + (sbmd_pkg::LIMIT_W + 1)'(sbmd_pkg::SUBQUEUES - 1);
  assign cap_c       = cap_sum_c[sbmd_pkg::LIMIT_W:SW];
  assign part_full_c = (limit_r != '0) && (sbmd_pkg::CAP_W'(put_cnt_c) >= cap_c);
  assign into_get_c  = (q_op.kind == sbmd_pkg::OP_PUT_FRONT) && (total_c > put_cnt_c);

  // Carry out the request at the head of the queue
  always_comb begin
    state_nxt    = state_r;
    put_rr_nxt   = put_rr_r;
    get_rr_nxt   = get_rr_r;
    upd_c        = 1'b0;
    wr_en_c      = 1'b0;
    load_c       = 1'b0;
    front_nxt    = front_c;
    total_nxt    = total_c;
    put_cnt_nxt  = put_cnt_c;
    wr_slot_c    = front_c + total_c[PW-1:0];
    res_status_c = sbmd_pkg::STAT_DONE;
    res_sub_c    = sub_c;
    if (q_pop) begin
      case (q_op.kind) inside
        sbmd_pkg::OP_PUT_BACK, sbmd_pkg::OP_PUT_FRONT: begin
          load_c = 1'b1;
          if (!into_get_c && !nonblk_r && part_full_c) begin
            res_status_c = sbmd_pkg::STAT_REFUSED;
          end else begin
            put_rr_nxt = put_rr_r + 1'b1;
            if (total_c[CW-1]) begin
              res_status_c = sbmd_pkg::STAT_DROPPED;
            end else begin
              upd_c     = 1'b1;
              wr_en_c   = 1'b1;
              total_nxt = total_c + 1'b1;
              if (!into_get_c) begin
                put_cnt_nxt = put_cnt_c + 1'b1;
              end
              if (q_op.kind == sbmd_pkg::OP_PUT_FRONT) begin
                front_nxt = front_c - 1'b1;
                wr_slot_c = front_c - 1'b1;
              end
            end
          end
        end
        sbmd_pkg::OP_GET: begin
          if (total_c == '0) begin
            load_c = 1'b1;
            if (nonblk_r) begin
              res_status_c = sbmd_pkg::STAT_EMPTY;
              get_rr_nxt   = get_rr_r + 1'b1;
            end else begin
              res_status_c = sbmd_pkg::STAT_REFUSED;
            end
          end else begin
            // Slot read is registered; the answer is formed in S_FETCH
            get_rr_nxt = get_rr_r + 1'b1;
            upd_c      = 1'b1;
            front_nxt  = front_c + 1'b1;
            total_nxt  = total_c - 1'b1;
            if (total_c == put_cnt_c) begin
              put_cnt_nxt = '0;
            end
            state_nxt = S_FETCH;
          end
        end
        default: begin
          load_c    = 1'b1;
          res_sub_c = '0;
        end
      endcase
    end else if (state_r == S_FETCH) begin
      state_nxt = S_RUN;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RUN;
      put_rr_r <= '0;
      get_rr_r <= '0;
      limit_r  <= '0;
      nonblk_r <= 1'b0;
      for (int i = 0; i < sbmd_pkg::SUBQUEUES; i++) begin
        front_ptr_r[i] <= '0;
        total_r[i]     <= '0;
        put_cnt_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      put_rr_r <= put_rr_nxt;
      get_rr_r <= get_rr_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sbmd_pkg::REG_QUEUE_LIMIT: limit_r  <= cfg_wdata;
          sbmd_pkg::REG_NONBLOCKING: nonblk_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (upd_c) begin
        front_ptr_r[sub_c] <= front_nxt;
        total_r[sub_c]     <= total_nxt;
        put_cnt_r[sub_c]   <= put_cnt_nxt;
      end
    end
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en_c) begin
      mem[{sub_c, wr_slot_c}] <= q_op.msg;
    end
    rd_data_r <= mem[{sub_c, front_c}];
  end

  // Response valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_c || state_r == S_FETCH) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_sub_r <= sub_c;
    end
    if (state_r == S_FETCH) begin
      out_msg_r    <= rd_data_r;
      out_status_r <= sbmd_pkg::STAT_DONE;
      out_sub_r    <= pend_sub_r;
    end else if (load_c) begin
      out_msg_r    <= '0;
      out_status_r <= res_status_c;
      out_sub_r    <= res_sub_c;
    end
  end

endmodule
